@@ rtl/dtss_pkg.sv @@
// shared types, constants and segment encoding for the six-digit decimal display encoder
`default_nettype none
package dtss_pkg;

    localparam int unsigned ValueWidth = 31;
    localparam int unsigned DigitCount = 6;
    localparam int unsigned BcdWidth   = 4 * DigitCount;
    localparam int unsigned CellCount  = ValueWidth;

    typedef logic [3:0] digit_t;
    typedef logic [7:0] seg_t;

    typedef struct packed {
        logic                  valid;
        logic [BcdWidth-1:0]   bcd;
        logic [ValueWidth-1:0] bin;
    } stage_t;

    // active high, segment a in bit 0
    function automatic seg_t seg_of(input digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ rtl/decimal_to_six_digit_seven_segment.sv @@
// top level: six-digit decimal seven-segment encoder
// path from input beat to result beat: 31 bcd cells, one per input bit, then the
// segment output register
// throughput one beat per cycle; the whole chain holds while a result beat waits
// synchronous active-low reset clears every valid flag; payload registers are not reset
`default_nettype none
module decimal_to_six_digit_seven_segment (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [30:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_low_digits_word,
    output logic [15:0]      m_high_digits_word
);

    logic             en;
    logic             digits_ok;
    dtss_pkg::stage_t chain [0:dtss_pkg::CellCount];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign chain[0].valid = s_valid;
    assign chain[0].bcd   = '0;
    assign chain[0].bin   = s_value;

    for (genvar k = 0; k < dtss_pkg::CellCount; k++) begin : g_cell
        dtss_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_stage  (chain[k]),
            .out_stage (chain[k+1])
        );
    end

    dtss_seg_stage u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_stage  (chain[dtss_pkg::CellCount]),
        .out_valid (m_valid),
        .low_word  (m_low_digits_word),
        .high_word (m_high_digits_word)
    );

    always_comb begin
        digits_ok = 1'b1;
        for (int i = 0; i < dtss_pkg::DigitCount; i++) begin
            if (chain[dtss_pkg::CellCount].bcd[4*i +: 4] > 4'd9) begin
                digits_ok = 1'b0;
            end
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> chain[1].valid)
        else $error("accepted beat did not enter the first cell");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(chain[dtss_pkg::CellCount].valid) && $stable(chain[1].valid))
        else $error("chain moved during a stall");

    a_digits_bcd: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[dtss_pkg::CellCount].valid |-> digits_ok)
        else $error("last cell holds a digit above nine");

endmodule
`default_nettype wire

@@ rtl/dtss_cell.sv @@
// one shift-and-add-three cell of the binary to bcd chain
`default_nettype none
module dtss_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire dtss_pkg::stage_t in_stage,
    output dtss_pkg::stage_t    out_stage
);

    logic                            valid_reg;
    logic [dtss_pkg::BcdWidth-1:0]   bcd_reg;
    logic [dtss_pkg::ValueWidth-1:0] bin_reg;
    dtss_pkg::stage_t stage_next;
    logic [dtss_pkg::BcdWidth-1:0] adj;

    always_comb begin
        for (int i = 0; i < dtss_pkg::DigitCount; i++) begin
            if (in_stage.bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = in_stage.bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = in_stage.bcd[4*i +: 4];
            end
        end
        stage_next.valid = in_stage.valid;
        // top digit overflow drops out, leaving the value modulo one million
        stage_next.bcd = {adj[dtss_pkg::BcdWidth-2:0], in_stage.bin[dtss_pkg::ValueWidth-1]};
        stage_next.bin = {in_stage.bin[dtss_pkg::ValueWidth-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bcd_reg <= stage_next.bcd;
            bin_reg <= stage_next.bin;
        end
    end

    assign out_stage = {valid_reg, bcd_reg, bin_reg};

endmodule
`default_nettype wire

@@ rtl/dtss_seg_stage.sv @@
// output register stage: bcd digits to packed segment words
`default_nettype none
module dtss_seg_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire dtss_pkg::stage_t in_stage,
    output logic                  out_valid,
    output logic [31:0]           low_word,
    output logic [15:0]           high_word
);

    logic        valid_reg;
    logic [31:0] low_reg;
    logic [31:0] low_next;
    logic [15:0] high_reg;
    logic [15:0] high_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            low_next[8*i +: 8] = dtss_pkg::seg_of(in_stage.bcd[4*i +: 4]);
        end
        for (int i = 0; i < 2; i++) begin
            high_next[8*i +: 8] = dtss_pkg::seg_of(in_stage.bcd[16 + 4*i +: 4]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign out_valid = valid_reg;
    assign low_word  = low_reg;
    assign high_word = high_reg;

endmodule
`default_nettype wire

@@ verif/decimal_to_six_digit_seven_segment_test.sv @@
// self-checking testbench for the six-digit decimal seven-segment encoder
module decimal_to_six_digit_seven_segment_test;

    localparam int unsigned CycleLimit = 500000;
    localparam int unsigned DrainCycles = 40;
    localparam int unsigned PhaseItems = 246;
    localparam dtss_pkg::seg_t Glyph [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef enum int {IdleNone, IdleFull, IdleSparse} idle_mode_t;

    typedef struct packed {
        logic [31:0] low_word;
        logic [15:0] high_word;
    } display_words_t;

    class display_scoreboard;
        display_words_t expected_q[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        function display_words_t predict_display(logic [30:0] value);
            display_words_t words;
            logic [31:0] rest;
            logic [3:0] digit;
            rest = {1'b0, value};
            rest = rest % 32'd1000000;
            words = '0;
            for (int i = 0; i < 6; i++) begin
                digit = 4'(rest % 32'd10);
                rest = rest / 32'd10;
                if (i < 4) begin
                    words.low_word[8*i +: 8] = Glyph[digit];
                end else begin
                    words.high_word[8*(i-4) +: 8] = Glyph[digit];
                end
            end
            return words;
        endfunction

        function void note_value(logic [30:0] value);
            expected_q.push_back(predict_display(value));
        endfunction

        function void check_display(logic [31:0] low_word, logic [15:0] high_word);
            display_words_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: low %h high %h",
                       low_word, high_word);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (low_word !== want.low_word) begin
                $error("m_low_digits_word: expected %h, actual %h", want.low_word, low_word);
                failures++;
            end
            if (high_word !== want.high_word) begin
                $error("m_high_digits_word: expected %h, actual %h",
                       want.high_word, high_word);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [30:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_low_digits_word;
    logic [15:0] m_high_digits_word;

    int unsigned cycle_count = 0;
    idle_mode_t sink_idle = IdleFull;
    display_scoreboard display_check = new();

    decimal_to_six_digit_seven_segment dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_value           (s_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_low_digits_word (m_low_digits_word),
        .m_high_digits_word(m_high_digits_word)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned draw_wait(idle_mode_t mode);
        case (mode)
            IdleNone: return 0;
            IdleFull: return $urandom_range(0, 16);
            default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    function automatic logic [30:0] draw_value();
        logic [31:0] base;
        case ($urandom_range(0, 4))
            0: return 31'($urandom());
            1: return 31'($urandom_range(0, 999999));
            2: begin
                base = $urandom_range(1, 2147) * 32'd1000000;
                if ($urandom_range(0, 1) == 0) begin
                    return 31'(base - 1 - $urandom_range(0, 9));
                end else begin
                    return 31'(base + $urandom_range(0, 9));
                end
            end
            3: return 31'($urandom_range(0, 99));
            default: return 31'h7FFF0000 | 31'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_value(input logic [30:0] value, input int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        display_check.note_value(value);
    endtask

    task automatic hold_off();
        s_valid <= 1'b0;
        while (display_check.pending() != 0) @(posedge aclk);
    endtask

    // result side
    initial begin
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = draw_wait(sink_idle);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            display_check.check_display(m_low_digits_word, m_high_digits_word);
        end
    end

    initial begin
        logic [30:0] corner_values [$];
        idle_mode_t source_modes [5];
        idle_mode_t sink_modes [5];
        corner_values = '{
            31'd0, 31'd1, 31'd9, 31'd10, 31'd99999, 31'd100000, 31'd999999,
            31'd1000000, 31'd1000001, 31'd1999999, 31'd123456, 31'd654321,
            31'd987654, 31'd9876543, 31'd1234567890, 31'd1073741824,
            31'd2147483646, 31'h7FFFFFFF, 31'd2147000000, 31'd555555
        };
        source_modes = '{IdleFull, IdleNone, IdleSparse, IdleFull, IdleSparse};
        sink_modes = '{IdleFull, IdleNone, IdleFull, IdleNone, IdleSparse};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (corner_values[i]) begin
            send_value(corner_values[i], draw_wait(IdleFull));
        end
        hold_off();

        for (int p = 0; p < 5; p++) begin
            sink_idle = sink_modes[p];
            for (int n = 0; n < PhaseItems; n++) begin
                send_value(draw_value(), draw_wait(source_modes[p]));
            end
            hold_off();
        end

        repeat (DrainCycles) @(posedge aclk);
        if (display_check.failures == 0 && display_check.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
